/* hdl/sound_register_translator_macros.svh */
// Assertion macros shared by the sound register translator RTL.
// Included by the files that carry concurrent assertions; needs a clock and reset in scope.
`ifndef SOUND_REGISTER_TRANSLATOR_MACROS_SVH
`define SOUND_REGISTER_TRANSLATOR_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SRT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("srt: implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SRT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("srt: next-cycle check failed");

`endif

/* hdl/srt_pkg.sv */
// Shared types, constants and helper functions of the sound register translator.
// No dependencies; every other file but the assertion macro header imports this package.
package srt_pkg;

   localparam int ADDR_W     = 8;
   localparam int MEM_DEPTH  = 32;
   localparam int MEM_AW     = 5;
   localparam int CLK_W      = 24;
   localparam int CSR_IDX_W  = 4;
   localparam int DIV_W      = 24;
   localparam int DVS_W      = 20;
   localparam int FREQ_W     = 13;
   localparam int RATE_W     = 15;
   localparam int DIV_CNT_W  = 5;
   localparam int FINE_PROD_W = 29;
   localparam int FINE_SHIFT  = 24;

   localparam logic [CSR_IDX_W-1:0] REG_TONE_CLOCK  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_NOISE_CLOCK = CSR_IDX_W'(1);

   localparam logic [CLK_W-1:0] CLOCK_RESET  = 24'd1773400;
   // fine*100/822 is fine times 100*ceil(2^24/822), shifted right by 24.
   // The rounding error stays below one step for every 8-bit fine value.
   localparam logic [20:0] FINE_RECIP = 21'd2041100;
   localparam logic [FREQ_W-1:0] FREQ_OFFSET = 13'd31;

   localparam logic [ADDR_W-1:0] ADDR_FINE_LO  = 8'd8;
   localparam logic [ADDR_W-1:0] ADDR_FINE_HI  = 8'd13;
   localparam logic [ADDR_W-1:0] ADDR_OCT_LO   = 8'd16;
   localparam logic [ADDR_W-1:0] ADDR_OCT_HI   = 8'd18;
   localparam logic [ADDR_W-1:0] ADDR_VOL_END  = 8'd6;
   localparam logic [ADDR_W-1:0] ADDR_NOISE    = 8'h16;
   localparam logic [ADDR_W-1:0] ADDR_TONE_EN  = 8'd20;
   localparam logic [ADDR_W-1:0] ADDR_NOISE_EN = 8'd21;

   localparam logic [3:0] TREG_NOISE = 4'd6;
   localparam logic [3:0] TREG_MIXER = 4'd7;
   localparam logic [3:0] TREG_VOL   = 4'd8;

   typedef enum logic [1:0] {
      DIV_TONE,
      DIV_NOISE
   } div_sel_type;

   typedef enum logic [2:0] {
      EMIT_VOL,
      EMIT_TLO,
      EMIT_THI,
      EMIT_NOISE,
      EMIT_MIX
   } emit_sel_type;

   typedef struct packed {
      logic              load;
      logic              rd_en;
      logic [MEM_AW-1:0] rd_addr;
      logic              cap_fine;
      logic              cap_oct;
      logic              cap_code;
      logic              cap_tones;
      logic              div_start;
      div_sel_type       div_sel;
      logic              set_freq;
      logic              emit;
      emit_sel_type      emit_sel;
      logic [2:0]        chan;
      logic              chip;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [7:0]        rdata;
      logic              div_busy;
      logic              div_done;
      logic              can_emit;
   } status_type;

   // Channel or address number modulo three, for values below eight.
   function automatic logic [1:0] mod3(input logic [2:0] x);
      logic [1:0] r;
      unique case (x)
         3'd0, 3'd3, 3'd6: r = 2'd0;
         3'd1, 3'd4, 3'd7: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   // Fixed noise rates for codes 0 to 2; code 3 takes a tone frequency instead.
   function automatic logic [RATE_W-1:0] noise_rate(input logic [1:0] code);
      logic [RATE_W-1:0] r;
      unique case (code)
         2'd0:    r = 15'd31300;
         2'd1:    r = 15'd15600;
         2'd2:    r = 15'd7600;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* hdl/srt_req_if.sv */
// Input channel of the sound register translator: one bus write per item.
// Depends on srt_pkg.
interface srt_req_if import srt_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] bus_byte;

   modport source (output valid, kind, bus_byte, input ready);
   modport sink (input valid, kind, bus_byte, output ready);
endinterface

/* hdl/srt_rsp_if.sv */
// Result channel of the sound register translator: one target chip write per item.
// Depends on srt_pkg.
interface srt_rsp_if import srt_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       target_chip;
   logic [3:0] target_register;
   logic [7:0] target_value;
   logic       last_of_run;

   modport source (output valid, target_chip, target_register, target_value, last_of_run,
                   input ready);
   modport sink (input valid, target_chip, target_register, target_value, last_of_run,
                 output ready);
endinterface

/* hdl/srt_csr_if.sv */
// Configuration write channel of the sound register translator.
// Depends on srt_pkg for the index width.
interface srt_csr_if import srt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CLK_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hdl/srt_div.sv */
// Restoring divider, one quotient bit per cycle, for tone and noise divisors.
// Depends on srt_pkg.
module srt_div import srt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             busy,
   output logic             done
);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       trial;
   logic [DVS_W+1:0]     diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};
   assign ge    = ~diff[DVS_W+1];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

/* hdl/srt_datapath.sv */
// Datapath: register file, clock registers, divider, operand registers and result register.
// Depends on srt_pkg, srt_rsp_if, srt_csr_if and srt_div.
module srt_datapath import srt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_kind,
   input  logic [7:0] req_bus_byte,
   srt_rsp_if.source  rsp,
   srt_csr_if.sink    csr,
   input  cmd_type    cmd,
   output status_type st
);

   logic [7:0]          mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff;
   logic [7:0]          rdata_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [7:0]          byte_ff;
   logic [CLK_W-1:0]    tone_clock_ff;
   logic [CLK_W-1:0]    noise_clock_ff;
   logic [7:0]          fine_ff;
   logic [2:0]          oct_ff;
   logic [1:0]          code_ff;
   logic [7:0]          tones_ff;
   logic [FREQ_W-1:0]   freq_ff;
   logic                rsp_valid_ff;
   logic                chip_ff;
   logic [3:0]          reg_ff;
   logic [7:0]          value_ff;
   logic                last_ff;

   logic [DIV_W-1:0]    dividend;
   logic [DVS_W-1:0]    divisor;
   logic [DIV_W-1:0]    quotient;
   logic                div_busy;
   logic                div_done;
   logic [RATE_W-1:0]   rate;
   logic                can_emit;
   logic [3:0]          reg_in;
   logic [7:0]          value_in;
   logic [2:0]          tmask;
   logic [2:0]          nmask;
   logic [FINE_PROD_W-1:0] fine_prod;

   srt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .busy     (div_busy),
      .done     (div_done)
   );

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_clock_ff  <= CLOCK_RESET;
         noise_clock_ff <= CLOCK_RESET;
      end else if (csr.valid) begin
         if (csr.index == REG_TONE_CLOCK) begin
            tone_clock_ff <= csr.data;
         end
         if (csr.index == REG_NOISE_CLOCK) begin
            noise_clock_ff <= csr.data;
         end
      end
   end

   // Register file: entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (cmd.load && req_kind) begin
         mem_ff[addr_ff[MEM_AW-1:0]] <= req_bus_byte;
      end
      if (cmd.rd_en) begin
         rdata_ff <= valid_ff[cmd.rd_addr] ? mem_ff[cmd.rd_addr] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         addr_ff  <= '0;
      end else if (cmd.load) begin
         if (req_kind) begin
            valid_ff[addr_ff[MEM_AW-1:0]] <= 1'b1;
         end else begin
            addr_ff <= req_bus_byte;
         end
      end
   end

   assign fine_prod = FINE_PROD_W'(fine_ff) * FINE_PROD_W'(FINE_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_bus_byte;
      end
      if (cmd.cap_fine) begin
         fine_ff <= rdata_ff;
      end
      if (cmd.cap_oct) begin
         oct_ff <= cmd.chan[0] ? rdata_ff[6:4] : rdata_ff[2:0];
      end
      if (cmd.cap_code) begin
         code_ff <= cmd.chip ? rdata_ff[5:4] : rdata_ff[1:0];
      end
      if (cmd.cap_tones) begin
         tones_ff <= rdata_ff;
      end
      if (cmd.set_freq) begin
         freq_ff <= (FREQ_W'(fine_prod[FINE_PROD_W-1:FINE_SHIFT]) + FREQ_OFFSET) << oct_ff;
      end
   end

   assign rate = (code_ff == 2'd3) ? RATE_W'(freq_ff) : noise_rate(code_ff);

   always_comb begin
      unique case (cmd.div_sel)
         DIV_TONE: begin
            dividend = tone_clock_ff;
            divisor  = DVS_W'(freq_ff) << 4;
         end
         DIV_NOISE: begin
            dividend = noise_clock_ff;
            divisor  = DVS_W'(rate) << 4;
         end
         default: begin
            dividend = tone_clock_ff;
            divisor  = DVS_W'(freq_ff) << 4;
         end
      endcase
   end

   assign tmask = cmd.chip ? tones_ff[5:3] : tones_ff[2:0];
   assign nmask = cmd.chip ? rdata_ff[5:3] : rdata_ff[2:0];

   always_comb begin
      unique case (cmd.emit_sel)
         EMIT_VOL: begin
            reg_in   = TREG_VOL + 4'(mod3(addr_ff[2:0]));
            value_in = {4'd0, byte_ff[7:4] | byte_ff[3:0]};
         end
         EMIT_TLO: begin
            reg_in   = {1'b0, mod3(cmd.chan), 1'b0};
            value_in = quotient[7:0];
         end
         EMIT_THI: begin
            reg_in   = {1'b0, mod3(cmd.chan), 1'b1};
            value_in = {4'd0, quotient[11:8]};
         end
         EMIT_NOISE: begin
            reg_in   = TREG_NOISE;
            value_in = {3'd0, quotient[4:0]};
         end
         EMIT_MIX: begin
            reg_in   = TREG_MIXER;
            // Noise on the first channel of a chip forces bit 0 high.
            value_in = {2'b11, ~nmask, ~tmask[2:1], ~tmask[0] | nmask[0]};
         end
         default: begin
            reg_in   = TREG_MIXER;
            value_in = 8'hFF;
         end
      endcase
   end

   assign can_emit = ~rsp_valid_ff | rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         chip_ff  <= cmd.chip;
         reg_ff   <= reg_in;
         value_ff <= value_in;
         last_ff  <= cmd.last;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.target_chip     = chip_ff;
   assign rsp.target_register = reg_ff;
   assign rsp.target_value    = value_ff;
   assign rsp.last_of_run     = last_ff;

   assign st.addr     = addr_ff;
   assign st.rdata    = rdata_ff;
   assign st.div_busy = div_busy;
   assign st.div_done = div_done;
   assign st.can_emit = can_emit;

endmodule

/* hdl/srt_ctrl.sv */
// Controller: loads each accepted bus write, decodes data writes and sequences reads, divisions and result writes.
// Depends on srt_pkg and the assertion macro header.
`include "sound_register_translator_macros.svh"

module srt_ctrl import srt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DECODE  = 5'd1;
   localparam logic [4:0] S_VOL     = 5'd2;
   localparam logic [4:0] S_T_RDF   = 5'd3;
   localparam logic [4:0] S_T_RDO   = 5'd4;
   localparam logic [4:0] S_T_OCT   = 5'd5;
   localparam logic [4:0] S_T_FREQ  = 5'd6;
   localparam logic [4:0] S_T_DIVT  = 5'd7;
   localparam logic [4:0] S_T_WAITT = 5'd8;
   localparam logic [4:0] S_T_LO    = 5'd9;
   localparam logic [4:0] S_T_HI    = 5'd10;
   localparam logic [4:0] S_N_RD    = 5'd11;
   localparam logic [4:0] S_N_CODE  = 5'd12;
   localparam logic [4:0] S_N_DIV   = 5'd13;
   localparam logic [4:0] S_N_WAIT  = 5'd14;
   localparam logic [4:0] S_N_EMIT  = 5'd15;
   localparam logic [4:0] S_M_RDT   = 5'd16;
   localparam logic [4:0] S_M_RDN   = 5'd17;
   localparam logic [4:0] S_M_EM0   = 5'd18;
   localparam logic [4:0] S_M_EM1   = 5'd19;

   logic [4:0] state_ff, state_in;
   logic [2:0] chan_ff, chan_in;
   logic       gen_ff, gen_in;
   logic       pair_ff, pair_in;
   logic       noise_ff, noise_in;
   logic [1:0] code_now;
   logic [ADDR_W-1:0] a;

   assign a        = st.addr;
   assign code_now = gen_ff ? st.rdata[5:4] : st.rdata[1:0];

   always_comb begin
      state_in  = state_ff;
      chan_in   = chan_ff;
      gen_in    = gen_ff;
      pair_in   = pair_ff;
      noise_in  = noise_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.div_sel  = DIV_TONE;
      cmd.emit_sel = EMIT_VOL;
      cmd.chan     = chan_ff;
      cmd.chip     = (chan_ff >= 3'd3);
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_kind) begin
                  state_in = S_DECODE;
               end
            end
         end
         S_DECODE: begin
            priority if (a < ADDR_VOL_END) begin
               state_in = S_VOL;
            end else if (a >= ADDR_FINE_LO && a <= ADDR_FINE_HI) begin
               chan_in  = a[2:0];
               pair_in  = 1'b0;
               noise_in = 1'b0;
               state_in = S_T_RDF;
            end else if (a >= ADDR_OCT_LO && a <= ADDR_OCT_HI) begin
               chan_in  = {a[1:0], 1'b0};
               pair_in  = 1'b1;
               noise_in = 1'b0;
               state_in = S_T_RDF;
            end else if (a == ADDR_NOISE) begin
               gen_in   = 1'b0;
               state_in = S_N_RD;
            end else if (a == ADDR_TONE_EN || a == ADDR_NOISE_EN) begin
               state_in = S_M_RDT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_VOL: begin
            cmd.chip = (a >= 8'd3);
            if (st.can_emit) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_T_RDF: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = ADDR_FINE_LO[MEM_AW-1:0] + MEM_AW'(chan_ff);
            state_in    = S_T_RDO;
         end
         S_T_RDO: begin
            cmd.cap_fine = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_addr  = ADDR_OCT_LO[MEM_AW-1:0] + MEM_AW'(chan_ff[2:1]);
            state_in     = S_T_OCT;
         end
         S_T_OCT: begin
            cmd.cap_oct = 1'b1;
            state_in    = S_T_FREQ;
         end
         S_T_FREQ: begin
            cmd.set_freq = 1'b1;
            state_in     = noise_ff ? S_N_DIV : S_T_DIVT;
         end
         S_T_DIVT: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TONE;
            state_in      = S_T_WAITT;
         end
         S_T_WAITT: begin
            if (st.div_done) begin
               state_in = S_T_LO;
            end
         end
         S_T_LO: begin
            cmd.emit_sel = EMIT_TLO;
            if (st.can_emit) begin
               cmd.emit = 1'b1;
               state_in = S_T_HI;
            end
         end
         S_T_HI: begin
            cmd.emit_sel = EMIT_THI;
            if (st.can_emit) begin
               cmd.emit = 1'b1;
               cmd.last = ~pair_ff;
               if (pair_ff) begin
                  chan_in  = chan_ff + 3'd1;
                  pair_in  = 1'b0;
                  state_in = S_T_RDF;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_N_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = ADDR_NOISE[MEM_AW-1:0];
            state_in    = S_N_CODE;
         end
         S_N_CODE: begin
            cmd.cap_code = 1'b1;
            cmd.chip     = gen_ff;
            // Code three borrows the tone frequency of the chip's first channel.
            if (code_now == 2'd3) begin
               chan_in  = gen_ff ? 3'd3 : 3'd0;
               noise_in = 1'b1;
               state_in = S_T_RDF;
            end else begin
               state_in = S_N_DIV;
            end
         end
         S_N_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_NOISE;
            state_in      = S_N_WAIT;
         end
         S_N_WAIT: begin
            if (st.div_done) begin
               state_in = S_N_EMIT;
            end
         end
         S_N_EMIT: begin
            cmd.emit_sel = EMIT_NOISE;
            cmd.chip     = gen_ff;
            if (st.can_emit) begin
               cmd.emit = 1'b1;
               cmd.last = gen_ff;
               if (gen_ff) begin
                  state_in = S_IDLE;
               end else begin
                  gen_in   = 1'b1;
                  state_in = S_N_RD;
               end
            end
         end
         S_M_RDT: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = ADDR_TONE_EN[MEM_AW-1:0];
            state_in    = S_M_RDN;
         end
         S_M_RDN: begin
            cmd.cap_tones = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_addr   = ADDR_NOISE_EN[MEM_AW-1:0];
            state_in      = S_M_EM0;
         end
         S_M_EM0: begin
            cmd.emit_sel = EMIT_MIX;
            cmd.chip     = 1'b0;
            if (st.can_emit) begin
               cmd.emit = 1'b1;
               state_in = S_M_EM1;
            end
         end
         S_M_EM1: begin
            cmd.emit_sel = EMIT_MIX;
            cmd.chip     = 1'b1;
            if (st.can_emit) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chan_ff  <= '0;
         gen_ff   <= 1'b0;
         pair_ff  <= 1'b0;
         noise_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         gen_ff   <= gen_in;
         pair_ff  <= pair_in;
         noise_ff <= noise_in;
      end
   end

   `SRT_ASSERT_IMP(a_emit_has_room, cmd.emit, st.can_emit)
   `SRT_ASSERT_IMP(a_div_start_idle, cmd.div_start, !st.div_busy)
   `SRT_ASSERT_NEXT(a_select_returns, state_ff == S_IDLE && req_valid && !req_kind,
                    state_ff == S_IDLE)
   `SRT_ASSERT_NEXT(a_last_ends_run, cmd.emit && cmd.last, state_ff == S_IDLE)

endmodule

/* hdl/sound_register_translator.sv */
// Sound register translator: mirrors writes to a six-channel sound register file
// onto register writes for two three-channel tone chips.
// Channels: req takes bus writes (kind 0 selects an address, kind 1 writes data);
// rsp returns target chip writes, last_of_run marking the final one of a data write;
// csr writes tone_clock (index 0) and noise_clock (index 1), always ready.
// Sequencing: an address select leaves the sequencer idle, so selects can follow back to
// back. A volume write passes through the decode and volume states before its result is
// registered. A tone channel retune costs one division for its two results; an octave
// write retunes two channels; a noise write costs one division per generator, plus a
// frequency computation for each generator that follows a tone frequency. The shared
// one-bit-per-cycle divider serves tone and noise writes; one item is in work at a time.
// Reset: clock registers return to 1773400, the selected address and all 32 register
// file entries read as zero; no clearing pass is needed.
// A stalled receiver holds the pending result in the output register; the sequencer
// waits before writing the next one, and no item is accepted until the run ends.
module sound_register_translator import srt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   srt_req_if.sink   req,
   srt_rsp_if.source rsp,
   srt_csr_if.sink   csr
);

   cmd_type    cmd;
   status_type st;

   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_kind  (req.kind),
      .req_ready (req.ready),
      .st        (st),
      .cmd       (cmd)
   );

   srt_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_kind     (req.kind),
      .req_bus_byte (req.bus_byte),
      .rsp          (rsp),
      .csr          (csr),
      .cmd          (cmd),
      .st           (st)
   );

endmodule
